// ===== rtl/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types and constants of the static linked list engine: command
// codes, controller states, datapath operations and the status bundle.
// ----------------------------------------------------------------------------
package sll_pkg;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 6;
   localparam int DATA_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_GET    = 3'd2,
      CMD_LOCATE = 3'd3,
      CMD_PRED   = 3'd4,
      CMD_SUCC   = 3'd5,
      CMD_CLEAR  = 3'd6
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_ALLOC,
      ST_HEAD_RD,
      ST_INS_HEAD,
      ST_WALK,
      ST_INS_LINK,
      ST_DEL_UNLINK,
      ST_DEL_FREE,
      ST_SUCC_TAKE,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_RD_HEAD,
      OP_RD_FREE,
      OP_ALLOC,
      OP_INS_HEAD,
      OP_ADVANCE,
      OP_INS_SPLICE,
      OP_INS_LINK,
      OP_DEL_UNLINK,
      OP_DEL_FREE,
      OP_RES_GET,
      OP_RES_LOC,
      OP_RES_PRED,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      cmd_type cmd;
      logic    pos_one;
      logic    pos_ok;
      logic    ins_ok;
      logic    count_zero;
      logic    count_le1;
      logic    hit_target;
      logic    at_last;
      logic    match;
      logic    step_ge2;
   } dp_status_type;

endpackage

// ===== rtl/static_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Array-backed singly linked list with a free chain, one command per
// transaction and one result per command.
// ----------------------------------------------------------------------------
// Each request transaction carries a command (insert, delete, get, locate,
// predecessor, successor or clear) and gives exactly one response
// transaction with ok, a value, a position, the length after the command
// and the empty and full flags. Node 0 is the null mark, so the list holds
// up to NODES-1 elements. Commands run one at a time: after set-up, the
// walk takes one read of the node memory per hop, since the registered link
// output of each read addresses the next read. Clear and rejected commands
// skip the walk. A finished command waits while a stalled response still
// holds the output register. A new request is taken once the previous
// command has reached the output register, even if that response is still
// stalled. Clear is immediate: nodes never used since reset or the last
// clear are tracked by a high-water mark and read back their reset
// free-chain link, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
   parameter int NODES      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sll_pkg::CMD_W-1:0]   req_cmd,
   input  logic [sll_pkg::POS_W-1:0]   req_position,
   input  logic [sll_pkg::DATA_W-1:0]  req_value,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [sll_pkg::DATA_W-1:0]  rsp_value_out,
   output logic [sll_pkg::POS_W-1:0]   rsp_position_out,
   output logic [sll_pkg::POS_W-1:0]   rsp_length_out,
   output logic                        rsp_empty_flag,
   output logic                        rsp_full_flag
);

   // controller -> datapath: one operation per cycle
   sll_pkg::dp_op_type     dp_op;
   // datapath -> controller: decoded command and walk comparisons
   sll_pkg::dp_status_type status;

   // sequencer: command decode, list walk and response handshake
   sll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .dp_op     (dp_op)
   );

   // node memories, pointers and the response payload register
   sll_datapath #(
      .NODES      (NODES),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_op            (dp_op),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_ok           (rsp_ok),
      .rsp_value_out    (rsp_value_out),
      .rsp_position_out (rsp_position_out),
      .rsp_length_out   (rsp_length_out),
      .rsp_empty_flag   (rsp_empty_flag),
      .rsp_full_flag    (rsp_full_flag)
   );

endmodule

// ===== rtl/sll_ctrl.sv =====
// ----------------------------------------------------------------------------
// sll_ctrl
// Command sequencer: decodes the latched command, steps through the list
// walk and the link updates, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sll_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  sll_pkg::dp_status_type status,
   output sll_pkg::dp_op_type     dp_op
);

   sll_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != sll_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sll_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == sll_pkg::ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sll_pkg::ST_IDLE: begin
            if (req_valid) state_in = sll_pkg::ST_START;
         end
         sll_pkg::ST_START: begin
            case (status.cmd)
               sll_pkg::CMD_INSERT:
                  state_in = status.ins_ok ? sll_pkg::ST_ALLOC : sll_pkg::ST_DONE;
               sll_pkg::CMD_DELETE: begin
                  if (!status.pos_ok)      state_in = sll_pkg::ST_DONE;
                  else if (status.pos_one) state_in = sll_pkg::ST_DEL_UNLINK;
                  else                     state_in = sll_pkg::ST_WALK;
               end
               sll_pkg::CMD_GET:
                  state_in = status.pos_ok ? sll_pkg::ST_WALK : sll_pkg::ST_DONE;
               sll_pkg::CMD_LOCATE, sll_pkg::CMD_PRED:
                  state_in = status.count_zero ? sll_pkg::ST_DONE : sll_pkg::ST_WALK;
               sll_pkg::CMD_SUCC:
                  state_in = status.count_le1 ? sll_pkg::ST_DONE : sll_pkg::ST_WALK;
               default:
                  state_in = sll_pkg::ST_DONE;
            endcase
         end
         sll_pkg::ST_ALLOC:
            state_in = status.pos_one ? sll_pkg::ST_INS_HEAD : sll_pkg::ST_HEAD_RD;
         sll_pkg::ST_HEAD_RD:  state_in = sll_pkg::ST_WALK;
         sll_pkg::ST_INS_HEAD: state_in = sll_pkg::ST_DONE;
         sll_pkg::ST_WALK: begin
            case (status.cmd)
               sll_pkg::CMD_INSERT: begin
                  if (status.hit_target) state_in = sll_pkg::ST_INS_LINK;
               end
               sll_pkg::CMD_DELETE: begin
                  if (status.hit_target) state_in = sll_pkg::ST_DEL_UNLINK;
               end
               sll_pkg::CMD_GET: begin
                  if (status.hit_target) state_in = sll_pkg::ST_DONE;
               end
               sll_pkg::CMD_LOCATE: begin
                  if (status.match || status.at_last) state_in = sll_pkg::ST_DONE;
               end
               sll_pkg::CMD_PRED: begin
                  if ((status.match && status.step_ge2) || status.at_last)
                     state_in = sll_pkg::ST_DONE;
               end
               sll_pkg::CMD_SUCC: begin
                  if (status.at_last)    state_in = sll_pkg::ST_DONE;
                  else if (status.match) state_in = sll_pkg::ST_SUCC_TAKE;
               end
               default: state_in = sll_pkg::ST_DONE;
            endcase
         end
         sll_pkg::ST_INS_LINK:   state_in = sll_pkg::ST_DONE;
         sll_pkg::ST_DEL_UNLINK: state_in = sll_pkg::ST_DEL_FREE;
         sll_pkg::ST_DEL_FREE:   state_in = sll_pkg::ST_DONE;
         sll_pkg::ST_SUCC_TAKE:  state_in = sll_pkg::ST_DONE;
         sll_pkg::ST_DONE: begin
            if (out_free) state_in = sll_pkg::ST_IDLE;
         end
         default: state_in = sll_pkg::ST_IDLE;
      endcase
   end

   // datapath operation
   always_comb begin
      dp_op = sll_pkg::OP_NONE;
      case (state_ff)
         sll_pkg::ST_IDLE: begin
            if (req_valid) dp_op = sll_pkg::OP_LOAD;
         end
         sll_pkg::ST_START: begin
            case (status.cmd)
               sll_pkg::CMD_INSERT: begin
                  if (status.ins_ok) dp_op = sll_pkg::OP_RD_FREE;
               end
               sll_pkg::CMD_DELETE, sll_pkg::CMD_GET: begin
                  if (status.pos_ok) dp_op = sll_pkg::OP_RD_HEAD;
               end
               sll_pkg::CMD_LOCATE, sll_pkg::CMD_PRED: begin
                  if (!status.count_zero) dp_op = sll_pkg::OP_RD_HEAD;
               end
               sll_pkg::CMD_SUCC: begin
                  if (!status.count_le1) dp_op = sll_pkg::OP_RD_HEAD;
               end
               sll_pkg::CMD_CLEAR: dp_op = sll_pkg::OP_CLEAR;
               default:            dp_op = sll_pkg::OP_NONE;
            endcase
         end
         sll_pkg::ST_ALLOC:    dp_op = sll_pkg::OP_ALLOC;
         sll_pkg::ST_HEAD_RD:  dp_op = sll_pkg::OP_RD_HEAD;
         sll_pkg::ST_INS_HEAD: dp_op = sll_pkg::OP_INS_HEAD;
         sll_pkg::ST_WALK: begin
            case (status.cmd)
               sll_pkg::CMD_INSERT:
                  dp_op = status.hit_target ? sll_pkg::OP_INS_SPLICE : sll_pkg::OP_ADVANCE;
               sll_pkg::CMD_DELETE:
                  dp_op = sll_pkg::OP_ADVANCE;
               sll_pkg::CMD_GET:
                  dp_op = status.hit_target ? sll_pkg::OP_RES_GET : sll_pkg::OP_ADVANCE;
               sll_pkg::CMD_LOCATE: begin
                  if (status.match)        dp_op = sll_pkg::OP_RES_LOC;
                  else if (!status.at_last) dp_op = sll_pkg::OP_ADVANCE;
               end
               sll_pkg::CMD_PRED: begin
                  if (status.match && status.step_ge2) dp_op = sll_pkg::OP_RES_PRED;
                  else if (!status.at_last)            dp_op = sll_pkg::OP_ADVANCE;
               end
               sll_pkg::CMD_SUCC: begin
                  if (!status.at_last) dp_op = sll_pkg::OP_ADVANCE;
               end
               default: dp_op = sll_pkg::OP_NONE;
            endcase
         end
         sll_pkg::ST_INS_LINK:   dp_op = sll_pkg::OP_INS_LINK;
         sll_pkg::ST_DEL_UNLINK: dp_op = sll_pkg::OP_DEL_UNLINK;
         sll_pkg::ST_DEL_FREE:   dp_op = sll_pkg::OP_DEL_FREE;
         sll_pkg::ST_SUCC_TAKE:  dp_op = sll_pkg::OP_RES_GET;
         sll_pkg::ST_DONE: begin
            if (out_free) dp_op = sll_pkg::OP_PUBLISH;
         end
         default: dp_op = sll_pkg::OP_NONE;
      endcase
   end

endmodule

// ===== rtl/sll_datapath.sv =====
// ----------------------------------------------------------------------------
// sll_datapath
// Node memories, list and free-chain pointers, walk registers and the
// result output register.
// ----------------------------------------------------------------------------
module sll_datapath #(
   parameter int NODES      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sll_pkg::dp_op_type          dp_op,
   output sll_pkg::dp_status_type      status,
   input  logic [sll_pkg::CMD_W-1:0]   req_cmd,
   input  logic [sll_pkg::POS_W-1:0]   req_position,
   input  logic [sll_pkg::DATA_W-1:0]  req_value,
   output logic                        rsp_ok,
   output logic [sll_pkg::DATA_W-1:0]  rsp_value_out,
   output logic [sll_pkg::POS_W-1:0]   rsp_position_out,
   output logic [sll_pkg::POS_W-1:0]   rsp_length_out,
   output logic                        rsp_empty_flag,
   output logic                        rsp_full_flag
);

   localparam int IW = $clog2(NODES);
   localparam int FW = IW + 1;
   localparam int LW = ((IW > sll_pkg::POS_W) ? IW : sll_pkg::POS_W) + 1;
   localparam int PW = sll_pkg::POS_W;
   localparam int EW = ELEM_WIDTH;

   // node store
   logic [EW-1:0] node_value_mem [NODES];
   logic [IW-1:0] node_link_mem  [NODES];

   // list bookkeeping (reset)
   logic [IW-1:0] list_head_ff, list_head_in;
   logic [IW-1:0] free_head_ff, free_head_in;
   logic [FW-1:0] fresh_ff, fresh_in;   // nodes at or above this read back their reset link
   logic [IW-1:0] count_ff, count_in;

   // transaction working registers
   sll_pkg::cmd_type cmd_ff;
   logic [PW-1:0] pos_ff;
   logic [EW-1:0] val_ff;
   logic [IW-1:0] cur_ff, prev_node_ff, alloc_ff;
   logic [LW-1:0] step_ff;
   logic [EW-1:0] prev_val_ff;
   logic          res_ok_ff;
   logic [EW-1:0] res_value_ff;
   logic [PW-1:0] res_pos_ff;

   // read port
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_value_ff;
   logic [IW-1:0] rd_link_ff;
   logic [IW-1:0] rd_addr_ff;
   logic          rd_fresh_ff;

   // write ports
   logic          val_we;
   logic          link_we;
   logic [IW-1:0] link_wa;
   logic [IW-1:0] link_wd;

   // output register
   logic          out_ok_ff;
   logic [sll_pkg::DATA_W-1:0] out_value_ff;
   logic [PW-1:0] out_pos_ff;
   logic [PW-1:0] out_len_ff;
   logic          out_empty_ff;
   logic          out_full_ff;

   logic [IW-1:0] link_eff;
   logic [IW-1:0] link_reset;
   logic [LW-1:0] pos_ext, count_ext, target;

   // untouched nodes follow the reset chain n -> n+1, last -> null
   assign link_reset = (rd_addr_ff == IW'(NODES - 1)) ? '0 : rd_addr_ff + IW'(1);
   assign link_eff   = rd_fresh_ff ? link_reset : rd_link_ff;

   assign pos_ext   = LW'(pos_ff);
   assign count_ext = LW'(count_ff);
   assign target    = (cmd_ff == sll_pkg::CMD_GET) ? pos_ext : pos_ext - LW'(1);

   always_comb begin
      status.cmd        = cmd_ff;
      status.pos_one    = (pos_ff == PW'(1));
      status.pos_ok     = (pos_ff != '0) && (pos_ext <= count_ext);
      status.ins_ok     = (pos_ff != '0) && (pos_ext <= count_ext + LW'(1))
                          && (free_head_ff != '0);
      status.count_zero = (count_ff == '0);
      status.count_le1  = (count_ff <= IW'(1));
      status.hit_target = (step_ff == target);
      status.at_last    = (step_ff == count_ext);
      status.match      = (rd_value_ff == val_ff);
      status.step_ge2   = (step_ff >= LW'(2));
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = list_head_ff;
      val_we  = 1'b0;
      link_we = 1'b0;
      link_wa = cur_ff;
      link_wd = free_head_ff;
      case (dp_op)
         sll_pkg::OP_RD_HEAD: begin
            rd_en   = 1'b1;
            rd_addr = list_head_ff;
         end
         sll_pkg::OP_RD_FREE: begin
            rd_en   = 1'b1;
            rd_addr = free_head_ff;
         end
         sll_pkg::OP_ADVANCE: begin
            rd_en   = 1'b1;
            rd_addr = link_eff;
         end
         sll_pkg::OP_ALLOC: val_we = 1'b1;
         sll_pkg::OP_INS_HEAD: begin
            link_we = 1'b1;
            link_wa = alloc_ff;
            link_wd = list_head_ff;
         end
         sll_pkg::OP_INS_SPLICE: begin
            link_we = 1'b1;
            link_wa = alloc_ff;
            link_wd = link_eff;
         end
         sll_pkg::OP_INS_LINK: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = alloc_ff;
         end
         sll_pkg::OP_DEL_UNLINK: begin
            link_we = !status.pos_one;
            link_wa = prev_node_ff;
            link_wd = link_eff;
         end
         sll_pkg::OP_DEL_FREE: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = free_head_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (val_we) node_value_mem[free_head_ff] <= val_ff;
      if (rd_en)  rd_value_ff <= node_value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) node_link_mem[link_wa] <= link_wd;
      if (rd_en) begin
         rd_link_ff  <= node_link_mem[rd_addr];
         rd_addr_ff  <= rd_addr;
         rd_fresh_ff <= ({1'b0, rd_addr} >= fresh_ff);
      end
   end

   // list bookkeeping next values
   always_comb begin
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      count_in     = count_ff;
      case (dp_op)
         sll_pkg::OP_CLEAR: begin
            list_head_in = '0;
            free_head_in = IW'(1);
            fresh_in     = FW'(1);
            count_in     = '0;
         end
         sll_pkg::OP_ALLOC: begin
            free_head_in = link_eff;
            if ({1'b0, free_head_ff} == fresh_ff) fresh_in = fresh_ff + FW'(1);
         end
         sll_pkg::OP_INS_HEAD: begin
            list_head_in = alloc_ff;
            count_in     = count_ff + IW'(1);
         end
         sll_pkg::OP_INS_LINK: count_in = count_ff + IW'(1);
         sll_pkg::OP_DEL_UNLINK: begin
            if (status.pos_one) list_head_in = link_eff;
         end
         sll_pkg::OP_DEL_FREE: begin
            free_head_in = cur_ff;
            count_in     = count_ff - IW'(1);
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_head_ff <= '0;
         free_head_ff <= IW'(1);
         fresh_ff     <= FW'(1);
         count_ff     <= '0;
      end else begin
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
      end
   end

   // working registers and result
   always_ff @(posedge clock) begin
      case (dp_op)
         sll_pkg::OP_LOAD: begin
            cmd_ff       <= sll_pkg::cmd_type'(req_cmd);
            pos_ff       <= req_position;
            val_ff       <= EW'(req_value);
            res_ok_ff    <= 1'b0;
            res_value_ff <= '0;
            res_pos_ff   <= '0;
         end
         sll_pkg::OP_CLEAR:    res_ok_ff <= 1'b1;
         sll_pkg::OP_ALLOC:    alloc_ff  <= free_head_ff;
         sll_pkg::OP_INS_HEAD: res_ok_ff <= 1'b1;
         sll_pkg::OP_INS_LINK: res_ok_ff <= 1'b1;
         sll_pkg::OP_RD_HEAD: begin
            cur_ff  <= list_head_ff;
            step_ff <= LW'(1);
         end
         sll_pkg::OP_ADVANCE: begin
            cur_ff       <= link_eff;
            prev_node_ff <= cur_ff;
            prev_val_ff  <= rd_value_ff;
            step_ff      <= step_ff + LW'(1);
         end
         sll_pkg::OP_DEL_UNLINK: res_value_ff <= rd_value_ff;
         sll_pkg::OP_DEL_FREE:   res_ok_ff    <= 1'b1;
         sll_pkg::OP_RES_GET: begin
            res_ok_ff    <= 1'b1;
            res_value_ff <= rd_value_ff;
         end
         sll_pkg::OP_RES_LOC: begin
            res_ok_ff  <= 1'b1;
            res_pos_ff <= PW'(step_ff);
         end
         sll_pkg::OP_RES_PRED: begin
            res_ok_ff    <= 1'b1;
            res_value_ff <= prev_val_ff;
         end
         sll_pkg::OP_PUBLISH: begin
            out_ok_ff    <= res_ok_ff;
            out_value_ff <= sll_pkg::DATA_W'(res_value_ff);
            out_pos_ff   <= res_pos_ff;
            out_len_ff   <= PW'(count_ff);
            out_empty_ff <= (count_ff == '0);
            out_full_ff  <= (free_head_ff == '0);
         end
         default: res_ok_ff <= res_ok_ff;
      endcase
   end

   assign rsp_ok           = out_ok_ff;
   assign rsp_value_out    = out_value_ff;
   assign rsp_position_out = out_pos_ff;
   assign rsp_length_out   = out_len_ff;
   assign rsp_empty_flag   = out_empty_ff;
   assign rsp_full_flag    = out_full_ff;

endmodule

// ===== tb/static_linked_list_engine_test.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_test
// Self-checking testbench for the static linked list engine. Commands are
// driven through the request channel and mirrored in a local model of the
// node store, link array, free chain and element count. Each response is
// checked field by field against the oldest predicted reply. Both channels
// see random idle and stall cycles, with a back-to-back stretch and a pause
// that lets the engine drain.
// ----------------------------------------------------------------------------
module static_linked_list_engine_test;

   localparam int NODE_COUNT     = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   // Allow a little over the worst walk when settling.
   localparam int SETTLE_CYCLES  = 80;
   // The command field is 3 bits wide, so code 7 exists but means nothing.
   localparam logic [sll_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

   typedef struct packed {
      logic                       ok;
      logic [sll_pkg::DATA_W-1:0] value;
      logic [sll_pkg::POS_W-1:0]  position;
      logic [sll_pkg::POS_W-1:0]  length;
      logic                       empty;
      logic                       full;
   } list_reply_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [sll_pkg::CMD_W-1:0]  req_cmd;
   logic [sll_pkg::POS_W-1:0]  req_position;
   logic [sll_pkg::DATA_W-1:0] req_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_ok;
   logic [sll_pkg::DATA_W-1:0] rsp_value_out;
   logic [sll_pkg::POS_W-1:0]  rsp_position_out;
   logic [sll_pkg::POS_W-1:0]  rsp_length_out;
   logic                       rsp_empty_flag;
   logic                       rsp_full_flag;

   // Mirror of the engine state, updated as each request transaction is taken.
   logic [sll_pkg::DATA_W-1:0] mirror_value [NODE_COUNT];
   int                         mirror_link  [NODE_COUNT];
   int                         mirror_head;
   int                         mirror_free;
   int                         mirror_count;

   list_reply_type    pending_replies [$];
   int                mismatches   = 0;
   int                stall_left   = 0;
   int                quiet_cycles = 0;
   bit                idle_enabled = 1'b1;

   static_linked_list_engine DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_value_out    (rsp_value_out),
      .rsp_position_out (rsp_position_out),
      .rsp_length_out   (rsp_length_out),
      .rsp_empty_flag   (rsp_empty_flag),
      .rsp_full_flag    (rsp_full_flag)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // List mirror
   // ---------------------------------------------------------------------

   // Free chain runs 1 -> 2 -> ... -> 63 -> null, list is empty.
   function automatic void rebuild_free_chain();
      int i;
      mirror_link[0] = 0;
      for (i = 1; i < NODE_COUNT - 1; i++)
         mirror_link[i] = i + 1;
      mirror_link[NODE_COUNT-1] = 0;
      mirror_head  = 0;
      mirror_free  = 1;
      mirror_count = 0;
   endfunction

   // Node holding 1-based position p; caller keeps p within the list.
   function automatic int node_at(int p);
      int n;
      int i;
      n = mirror_head;
      for (i = 1; i < p; i++)
         n = mirror_link[n];
      return n;
   endfunction

   function automatic list_reply_type apply_list_command(
         logic [sll_pkg::CMD_W-1:0] cmd, int pos, logic [sll_pkg::DATA_W-1:0] val);
      list_reply_type r;
      int             n;
      int             prev;
      int             f;
      int             i;
      r = '0;
      case (cmd)
         sll_pkg::CMD_INSERT: begin
            if (pos >= 1 && pos <= mirror_count + 1 && mirror_free != 0) begin
               f = mirror_free;
               mirror_free = mirror_link[f];
               mirror_value[f] = val;
               if (pos == 1) begin
                  mirror_link[f] = mirror_head;
                  mirror_head = f;
               end else begin
                  prev = node_at(pos - 1);
                  mirror_link[f] = mirror_link[prev];
                  mirror_link[prev] = f;
               end
               mirror_count++;
               r.ok = 1'b1;
            end
         end
         sll_pkg::CMD_DELETE: begin
            if (pos >= 1 && pos <= mirror_count) begin
               if (pos == 1) begin
                  n = mirror_head;
                  mirror_head = mirror_link[n];
               end else begin
                  prev = node_at(pos - 1);
                  n = mirror_link[prev];
                  mirror_link[prev] = mirror_link[n];
               end
               r.value = mirror_value[n];
               mirror_link[n] = mirror_free;
               mirror_free = n;
               mirror_count--;
               r.ok = 1'b1;
            end
         end
         sll_pkg::CMD_GET: begin
            if (pos >= 1 && pos <= mirror_count) begin
               r.value = mirror_value[node_at(pos)];
               r.ok = 1'b1;
            end
         end
         sll_pkg::CMD_LOCATE: begin
            n = mirror_head;
            i = 1;
            while (i <= mirror_count && !r.ok) begin
               if (mirror_value[n] == val) begin
                  r.ok = 1'b1;
                  r.position = sll_pkg::POS_W'(i);
               end
               n = mirror_link[n];
               i++;
            end
         end
         sll_pkg::CMD_PRED: begin
            // a hit at the head has no predecessor, keep looking further on
            n = mirror_head;
            prev = 0;
            i = 1;
            while (i <= mirror_count && !r.ok) begin
               if (i >= 2 && mirror_value[n] == val) begin
                  r.ok = 1'b1;
                  r.value = mirror_value[prev];
               end else begin
                  prev = n;
                  n = mirror_link[n];
               end
               i++;
            end
         end
         sll_pkg::CMD_SUCC: begin
            // the last element is never tested: it has no successor
            n = mirror_head;
            i = 1;
            while (i < mirror_count && !r.ok) begin
               if (mirror_value[n] == val) begin
                  r.ok = 1'b1;
                  r.value = mirror_value[mirror_link[n]];
               end else begin
                  n = mirror_link[n];
               end
               i++;
            end
         end
         sll_pkg::CMD_CLEAR: begin
            rebuild_free_chain();
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.length = sll_pkg::POS_W'(mirror_count);
      r.empty  = (mirror_count == 0);
      r.full   = (mirror_free == 0);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Presents one transaction after a random gap and waits until it is taken.
   // Valid stays high on return, so the next call can follow back to back.
   task automatic send_command(input logic [sll_pkg::CMD_W-1:0] cmd, input int pos,
                               input logic [sll_pkg::DATA_W-1:0] val);
      int gap;
      gap = idle_enabled ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd      = cmd;
      req_position = sll_pkg::POS_W'(pos);
      req_value    = val;
      req_valid    = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_replies.push_back(apply_list_command(cmd, pos, val));
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_replies();
      release_request();
      while (pending_replies.size() != 0)
         @(posedge clock);
   endtask

   // Small pool for repeated values, plus the extremes and full random words.
   function automatic logic [sll_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return $urandom_range(1, 12);
         default:    return $urandom();
      endcase
   endfunction

   // Searches mostly look for something that is stored.
   function automatic logic [sll_pkg::DATA_W-1:0] pick_search_value();
      if (mirror_count != 0 && $urandom_range(0, 3) != 0)
         return mirror_value[node_at($urandom_range(1, mirror_count))];
      return pick_value();
   endfunction

   function automatic int pick_position(logic [sll_pkg::CMD_W-1:0] cmd);
      int limit;
      limit = (cmd == sll_pkg::CMD_INSERT) ? mirror_count + 1 : mirror_count;
      if (limit > NODE_COUNT - 1)
         limit = NODE_COUNT - 1;
      if (limit == 0 || $urandom_range(0, 9) == 0)
         return $urandom_range(0, NODE_COUNT - 1);
      case ($urandom_range(0, 5))
         0:       return 1;
         1:       return limit;
         default: return $urandom_range(1, limit);
      endcase
   endfunction

   function automatic logic [sll_pkg::CMD_W-1:0] pick_command(int grow_pct, int clear_pct);
      int n;
      if ($urandom_range(0, 99) < grow_pct)
         return sll_pkg::CMD_INSERT;
      if ($urandom_range(0, 99) < clear_pct)
         return sll_pkg::CMD_CLEAR;
      n = $urandom_range(0, 99);
      if (n < 30) return sll_pkg::CMD_DELETE;
      if (n < 48) return sll_pkg::CMD_GET;
      if (n < 64) return sll_pkg::CMD_LOCATE;
      if (n < 80) return sll_pkg::CMD_PRED;
      if (n < 97) return sll_pkg::CMD_SUCC;
      return CMD_UNUSED;
   endfunction

   task automatic send_random(input int grow_pct, input int clear_pct);
      logic [sll_pkg::CMD_W-1:0] cmd;
      cmd = pick_command(grow_pct, clear_pct);
      if (cmd == sll_pkg::CMD_LOCATE || cmd == sll_pkg::CMD_PRED
          || cmd == sll_pkg::CMD_SUCC)
         send_command(cmd, pick_position(cmd), pick_search_value());
      else
         send_command(cmd, pick_position(cmd), pick_value());
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Stall is held for a freshly drawn number of cycles after every response.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] response mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [sll_pkg::DATA_W-1:0] want,
                              input logic [sll_pkg::DATA_W-1:0] got);
      if (want !== got)
         report_mismatch($sformatf("%s expected %h actual %h", name, want, got));
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = idle_enabled ? $urandom_range(0, 5) : 0;
         if (pending_replies.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            want = pending_replies.pop_front();
            check_field("ok", sll_pkg::DATA_W'(want.ok), sll_pkg::DATA_W'(rsp_ok));
            check_field("value", want.value, rsp_value_out);
            check_field("position", sll_pkg::DATA_W'(want.position),
                        sll_pkg::DATA_W'(rsp_position_out));
            check_field("length", sll_pkg::DATA_W'(want.length),
                        sll_pkg::DATA_W'(rsp_length_out));
            check_field("empty", sll_pkg::DATA_W'(want.empty),
                        sll_pkg::DATA_W'(rsp_empty_flag));
            check_field("full", sll_pkg::DATA_W'(want.full),
                        sll_pkg::DATA_W'(rsp_full_flag));
         end
      end
   end

   // Watchdog: a long run of cycles with no transaction on either side means
   // the engine has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every command but clear against the empty list straight after reset.
   task automatic test_empty_list();
      send_command(sll_pkg::CMD_GET,    1, '0);
      send_command(sll_pkg::CMD_DELETE, 1, '0);
      send_command(sll_pkg::CMD_LOCATE, 0, '0);
      send_command(sll_pkg::CMD_PRED,   0, '1);
      send_command(sll_pkg::CMD_SUCC,   0, '1);
      send_command(sll_pkg::CMD_INSERT, 0, 32'h1234_5678);    // position zero rejected
      send_command(sll_pkg::CMD_INSERT, 2, 32'h1234_5678);    // past the end rejected
      send_command(CMD_UNUSED, NODE_COUNT - 1, '1);
   endtask

   // Head, tail and middle handling on a short list, then clear.
   task automatic test_edge_cases();
      send_command(sll_pkg::CMD_INSERT, 1, '1);
      send_command(sll_pkg::CMD_INSERT, 2, '0);
      send_command(sll_pkg::CMD_INSERT, 1, 32'd5);            // new head: 5 F 0
      send_command(sll_pkg::CMD_INSERT, 4, '0);               // append: 5 F 0 0
      send_command(sll_pkg::CMD_GET,    4, '0);
      send_command(sll_pkg::CMD_GET,    5, '0);               // one past the end
      send_command(sll_pkg::CMD_LOCATE, 0, '0);               // first of two copies
      send_command(sll_pkg::CMD_PRED,   0, 32'd5);            // only at the head
      send_command(sll_pkg::CMD_PRED,   0, '1);
      send_command(sll_pkg::CMD_SUCC,   0, '0);               // first copy is not last
      send_command(sll_pkg::CMD_INSERT, 5, 32'd9);
      send_command(sll_pkg::CMD_SUCC,   0, 32'd9);            // only at the tail
      send_command(sll_pkg::CMD_LOCATE, 0, 32'd77);           // absent
      send_command(sll_pkg::CMD_DELETE, 1, '0);
      send_command(sll_pkg::CMD_DELETE, NODE_COUNT - 1, '0);
      send_command(sll_pkg::CMD_DELETE, 4, '0);               // tail
      send_command(sll_pkg::CMD_CLEAR,  0, '0);
      send_command(sll_pkg::CMD_GET,    1, '0);
   endtask

   // Fill every node, try two more inserts, probe the full list, then empty it.
   task automatic test_fill_and_overflow();
      int i;
      send_command(sll_pkg::CMD_CLEAR, 0, '0);
      for (i = 0; i < NODE_COUNT - 1; i++)
         send_command(sll_pkg::CMD_INSERT, $urandom_range(1, mirror_count + 1),
                      pick_value());
      send_command(sll_pkg::CMD_INSERT, 1, pick_value());
      send_command(sll_pkg::CMD_INSERT, NODE_COUNT - 1, pick_value());
      send_command(sll_pkg::CMD_GET, NODE_COUNT - 1, '0);
      send_command(sll_pkg::CMD_LOCATE, 0, mirror_value[node_at(NODE_COUNT - 1)]);
      send_command(sll_pkg::CMD_SUCC, 0, mirror_value[node_at(NODE_COUNT - 2)]);
      send_command(sll_pkg::CMD_PRED, 0, mirror_value[node_at(NODE_COUNT - 1)]);
      send_command(sll_pkg::CMD_DELETE, NODE_COUNT - 1, '0);
      send_command(sll_pkg::CMD_INSERT, NODE_COUNT - 1, pick_value());
      while (mirror_count > 0)
         send_command(sll_pkg::CMD_DELETE, $urandom_range(1, mirror_count), '0);
      send_command(sll_pkg::CMD_DELETE, 1, '0);
   endtask

   task automatic test_random_traffic(input int items, input int grow_pct,
                                      input int clear_pct);
      repeat (items) send_random(grow_pct, clear_pct);
   endtask

   // Let the engine drain completely, then restart with a burst.
   task automatic test_pause_and_resume();
      wait_for_replies();
      test_random_traffic(250, 45, 1);
   endtask

   // No idle or stall cycles on either side.
   task automatic test_back_to_back();
      idle_enabled = 1'b0;
      test_random_traffic(250, 50, 1);
      idle_enabled = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = sll_pkg::CMD_GET;
      req_position = '0;
      req_value    = '0;
      rsp_stall    = 1'b0;
      rebuild_free_chain();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_edge_cases();
      test_fill_and_overflow();
      test_random_traffic(590, 60, 0);     // grows until the list fills
      test_random_traffic(300, 25, 1);     // mostly shrinking, with clears
      test_back_to_back();
      test_pause_and_resume();

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sll_pkg.sv
rtl/sll_ctrl.sv
rtl/sll_datapath.sv
rtl/static_linked_list_engine.sv
tb/static_linked_list_engine_test.sv
